// ===== hw/rtl/fsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsp_pkg
// Types and constants shared by the field serializer / packer.
// ----------------------------------------------------------------------------
package fsp_pkg;

  localparam int QueueDepth = 2;

  typedef enum logic [1:0] {
    MODE_INT  = 2'd0,
    MODE_DBL  = 2'd1,
    MODE_BYTE = 2'd2,
    MODE_RSVD = 2'd3
  } mode_t;

  localparam logic [7:0] FLAG_NEG  = 8'h01;
  localparam logic [7:0] FLAG_NAN  = 8'h02;
  localparam logic [7:0] FLAG_INF  = 8'h04;
  localparam logic [7:0] FLAG_ZERO = 8'h08;

  typedef struct packed {
    logic [1:0]  mode;
    logic        big_endian;
    logic [63:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  // Classified field: up to 11 bytes held as a byte list in emit order.
  typedef struct packed {
    logic [10:0][7:0] bytes;
    logic [3:0]       count;
  } job_t;

endpackage

// ===== hw/rtl/fsp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsp_front
// Two-stage classifier: leading-one search, then decode and byte list build.
// ----------------------------------------------------------------------------
module fsp_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             valid,
  output logic             stall,
  input  fsp_pkg::in_item_t item,
  output logic             job_valid,
  input  logic             job_stall,
  output fsp_pkg::job_t    job
);
  import fsp_pkg::*;

  // stage 1 registers
  logic        s1_valid;
  logic [1:0]  s1_mode;
  logic        s1_be;
  logic [63:0] s1_value;
  logic [5:0]  s1_p;
  logic        adv2;
  logic        adv1;

  logic [5:0]  p_calc;
  logic [51:0] frac_in;

  assign frac_in = item.value[51:0];

  // priority search for top set bit in bits 51..1 (0 when none)
  always_comb begin
    p_calc = 6'd0;
    for (int i = 1; i < 52; i++) begin
      if (frac_in[i]) p_calc = 6'(i);
    end
  end

  assign adv2  = s1_valid && !(job_valid && job_stall);
  assign adv1  = !s1_valid || adv2;
  assign stall = !adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv1) begin
      s1_valid <= valid;
    end
    if (adv1 && valid) begin
      s1_mode  <= item.mode;
      s1_be    <= item.big_endian;
      s1_value <= item.value;
      s1_p     <= p_calc;
    end
  end

  // stage 2: build the byte list
  logic        sign;
  logic [10:0] ef;
  logic [51:0] frac;
  logic [7:0]  flag;
  logic [15:0] ex;
  logic [63:0] mant;
  job_t        job_next;

  always_comb begin
    sign = s1_value[63];
    ef   = s1_value[62:52];
    frac = s1_value[51:0];
    if (ef == 11'h7ff && frac != '0) flag = FLAG_NAN;
    else if (ef == 11'h7ff) flag = (sign ? FLAG_NEG : 8'h00) | FLAG_INF;
    else if (ef == '0 && frac == '0) flag = (sign ? FLAG_NEG : 8'h00) | FLAG_ZERO;
    else flag = sign ? FLAG_NEG : 8'h00;
    if (ef != '0) begin
      ex   = 16'({5'd0, ef}) - 16'd1022;
      mant = {12'd0, frac};
    end else begin
      ex   = 16'({10'd0, s1_p}) - 16'd1073;
      mant = {12'd0, 52'(frac << (7'd52 - {1'b0, s1_p}))};
    end
    job_next = '0;
    case (mode_t'(s1_mode))
      MODE_INT: begin
        for (int i = 0; i < 8; i++)
          job_next.bytes[i] = s1_be ? s1_value[8*(7-i) +: 8] : s1_value[8*i +: 8];
        job_next.count = 4'd8;
      end
      MODE_DBL: begin
        job_next.bytes[0] = flag;
        if ((flag & (FLAG_NAN | FLAG_INF | FLAG_ZERO)) == '0) begin
          job_next.bytes[1] = s1_be ? ex[15:8] : ex[7:0];
          job_next.bytes[2] = s1_be ? ex[7:0] : ex[15:8];
          for (int i = 0; i < 8; i++)
            job_next.bytes[3+i] = s1_be ? mant[8*(7-i) +: 8] : mant[8*i +: 8];
          job_next.count = 4'd11;
        end else begin
          job_next.count = 4'd1;
        end
      end
      default: begin
        job_next.bytes[0] = s1_value[7:0];
        job_next.count    = 4'd1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (!(job_valid && job_stall)) begin
      job_valid <= s1_valid;
    end
    if (adv2) job <= job_next;
  end

endmodule

// ===== hw/rtl/fsp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsp_queue
// Small register FIFO between classifier and byte emitter.
// ----------------------------------------------------------------------------
module fsp_queue #(
  parameter int Depth = fsp_pkg::QueueDepth
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_stall,
  input  fsp_pkg::job_t wr_data,
  output logic          rd_valid,
  input  logic          rd_stall,
  output fsp_pkg::job_t rd_data
);
  import fsp_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  job_t            mem [Depth];
  logic [AW-1:0]   wp, rp;
  logic [AW:0]     cnt;
  logic            wr, rd;

  assign wr_stall = (cnt == (AW+1)'(Depth));
  assign rd_valid = (cnt != '0);
  assign rd_data  = mem[rp];
  assign wr = wr_valid && !wr_stall;
  assign rd = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) wp <= (wp == AW'(Depth-1)) ? '0 : wp + 1'b1;
      if (rd) rp <= (rp == AW'(Depth-1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(wr) - (AW+1)'(rd);
    end
    if (wr) mem[wp] <= wr_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cnt <= (AW+1)'(Depth)) else $error("queue count over depth");
  a_empty_no_valid: assert property (@(posedge clk) disable iff (rst)
    (cnt == '0) |-> !rd_valid) else $error("valid while empty");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (wr && !rd) |=> cnt == $past(cnt) + 1'b1) else $error("count step");

endmodule

// ===== hw/rtl/fsp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsp_back
// Byte emitter: walks job bytes to out register, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module fsp_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  output logic               job_stall,
  input  fsp_pkg::job_t      job,
  output logic               valid,
  input  logic               stall,
  output fsp_pkg::out_item_t item
);
  import fsp_pkg::*;

  logic [3:0] idx;
  logic       load;
  logic       fin;

  assign load      = job_valid && !(valid && stall);
  assign fin       = (idx + 4'd1 == job.count);
  assign job_stall = !(load && fin);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else begin
      if (!(valid && stall)) valid <= job_valid;
      if (load) idx <= fin ? 4'd0 : idx + 4'd1;
    end
    if (load) begin
      item.out_byte <= job.bytes[idx];
      item.last     <= fin;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> idx < job.count) else $error("index past byte count");
  a_pop_on_last: assert property (@(posedge clk) disable iff (rst)
    (job_valid && !job_stall) |=> valid && item.last) else $error("pop without last");
  a_idx_reset: assert property (@(posedge clk) disable iff (rst)
    (job_valid && !job_stall) |=> idx == '0) else $error("index not rewound");

endmodule

// ===== hw/rtl/field_serializer_packer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// field_serializer_packer_top
// Serializes integer, double and raw-byte fields into a byte stream.
// ----------------------------------------------------------------------------
// An accepted item passes the stage 1 and job registers and a queue entry
// before its first byte reaches the output register. The emitter sends one
// byte per cycle unless the output stalls; an item has 1, 8 or 11 bytes.
// The classifier and a 2-entry job queue absorb the next items meanwhile.
// Reset: synchronous rst empties the pipeline and queue; no state otherwise.
module field_serializer_packer_top #(
  parameter int QDepth = fsp_pkg::QueueDepth
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  fsp_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output fsp_pkg::out_item_t out_item
);
  import fsp_pkg::*;

  logic f_valid, f_stall, q_valid, q_stall;
  job_t f_job, q_job;

  fsp_front u_front (
    .clk, .rst,
    .valid(in_valid), .stall(in_stall), .item(in_item),
    .job_valid(f_valid), .job_stall(f_stall), .job(f_job)
  );

  fsp_queue #(.Depth(QDepth)) u_queue (
    .clk, .rst,
    .wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_job),
    .rd_valid(q_valid), .rd_stall(q_stall), .rd_data(q_job)
  );

  fsp_back u_back (
    .clk, .rst,
    .job_valid(q_valid), .job_stall(q_stall), .job(q_job),
    .valid(out_valid), .stall(out_stall), .item(out_item)
  );

endmodule

// ===== dv/field_serializer_packer_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// field_serializer_packer_top_tb
// Self-checking bench for the field serializer: integer, double and raw-byte
// fields with random endianness, random input idle gaps and output stalls.
// ----------------------------------------------------------------------------

class byte_stream_board;
  fsp_pkg::out_item_t expected_bytes[$];
  int mismatches;

  function void push_byte(logic [7:0] b, logic is_last);
    fsp_pkg::out_item_t o;
    o.out_byte = b;
    o.last = is_last;
    expected_bytes.push_back(o);
  endfunction

  function void push_word(logic [63:0] w, int nbytes, logic be);
    int i;
    int sh;
    for (i = 0; i < nbytes; i++) begin
      sh = be ? 8 * (nbytes - 1 - i) : 8 * i;
      push_byte(8'(w >> sh), 1'b0);
    end
  endfunction

  // Works out the byte stream of one accepted field.
  function void note_field(fsp_pkg::in_item_t it);
    logic [10:0] ef;
    logic [51:0] frac;
    logic [7:0] flag;
    logic sign;
    int p;
    int e;
    logic [63:0] m;
    fsp_pkg::out_item_t tail;
    sign = it.value[63];
    ef = it.value[62:52];
    frac = it.value[51:0];
    case (fsp_pkg::mode_t'(it.mode))
      fsp_pkg::MODE_INT: begin
        push_word(it.value, 8, it.big_endian);
      end
      fsp_pkg::MODE_DBL: begin
        if (ef == 11'h7ff && frac != 0) flag = fsp_pkg::FLAG_NAN;
        else if (ef == 11'h7ff) flag = (sign ? fsp_pkg::FLAG_NEG : 8'h0) | fsp_pkg::FLAG_INF;
        else if (ef == 0 && frac == 0)
          flag = (sign ? fsp_pkg::FLAG_NEG : 8'h0) | fsp_pkg::FLAG_ZERO;
        else flag = sign ? fsp_pkg::FLAG_NEG : 8'h0;
        push_byte(flag, 1'b0);
        if ((flag & (fsp_pkg::FLAG_NAN | fsp_pkg::FLAG_INF | fsp_pkg::FLAG_ZERO)) == 0) begin
          if (ef != 0) begin
            e = int'(ef) - 1022;
            m = {12'h0, frac};
          end else begin
            // subnormal: normalize on the leading one
            p = 51;
            while (p > 0 && frac[p] == 1'b0) p--;
            e = p - 1073;
            m = {12'h0, frac} << (52 - p);
            m = m & 64'h000f_ffff_ffff_ffff;
          end
          push_word(64'(e[15:0]), 2, it.big_endian);
          push_word(m, 8, it.big_endian);
        end
      end
      default: begin
        push_byte(it.value[7:0], 1'b0);
      end
    endcase
    tail = expected_bytes.pop_back();
    tail.last = 1'b1;
    expected_bytes.push_back(tail);
  endfunction

  function void check_byte(fsp_pkg::out_item_t got);
    fsp_pkg::out_item_t exp;
    if (expected_bytes.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected byte %02h last %0d", got.out_byte, got.last);
      return;
    end
    exp = expected_bytes.pop_front();
    if (got.out_byte !== exp.out_byte || got.last !== exp.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("byte mismatch: expected %02h last %0d, got %02h last %0d",
                 exp.out_byte, exp.last, got.out_byte, got.last);
    end
  endfunction
endclass

module field_serializer_packer_top_tb;
  import fsp_pkg::*;

  localparam int CycleLimit = 200000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_item_t in_item;
  logic out_valid;
  logic out_stall;
  out_item_t out_item;

  byte_stream_board board;
  int cycles = 0;
  bit long_hold;
  bit hold_done;
  bit random_stall;

  field_serializer_packer_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Output side: check every accepted byte.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_byte(out_item);
  end

  // Receiver stall: random waits, or one long hold-off when requested.
  initial begin : receiver
    int w;
    out_stall = 1'b0;
    hold_done = 1'b0;
    @(posedge clk);
    while (1) begin
      if (long_hold && !hold_done) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_done = 1'b1;
      end else if (random_stall) begin
        w = $urandom_range(0, 18);
        if (w > 0) begin
          out_stall <= 1'b1;
          repeat (w) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  task automatic send_field(logic [1:0] m, logic be, logic [63:0] v, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{mode: m, big_endian: be, value: v};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_field(in_item);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.expected_bytes.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Mostly doubles with interesting exponent fields.
  function automatic logic [63:0] rand_double();
    logic [63:0] v;
    int k;
    v = rand64();
    k = $urandom_range(0, 9);
    if (k == 0) v[62:52] = 11'h0;
    else if (k == 1) v[62:52] = 11'h7ff;
    else if (k == 2) v[62:0] = 63'h0;
    else if (k == 3) begin
      v[62:52] = 11'h0;
      v[51:0] = 52'h1 << $urandom_range(0, 51);
    end else if (k == 4) v[62:52] = $urandom_range(0, 1) ? 11'h1 : 11'h7fe;
    return v;
  endfunction

  initial begin : stimulus
    int i;
    logic [1:0] m;
    board = new();
    long_hold = 1'b0;
    random_stall = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes and every double case
    send_field(MODE_INT, 1'b0, 64'h0123_4567_89ab_cdef, 0);
    send_field(MODE_INT, 1'b1, 64'h0123_4567_89ab_cdef, 0);
    send_field(MODE_INT, 1'b0, 64'h0, 0);
    send_field(MODE_INT, 1'b1, 64'hffff_ffff_ffff_ffff, 0);
    send_field(MODE_BYTE, 1'b0, 64'hffff_ffff_ffff_ff5a, 0);
    send_field(MODE_BYTE, 1'b1, 64'h0, 0);
    send_field(MODE_RSVD, 1'b0, 64'hdead_beef_0000_00a5, 0);
    send_field(MODE_DBL, 1'b0, 64'h7ff8_0000_0000_0000, 0);
    send_field(MODE_DBL, 1'b1, 64'hfff0_0000_0000_0001, 0);
    send_field(MODE_DBL, 1'b0, 64'h7ff0_0000_0000_0000, 0);
    send_field(MODE_DBL, 1'b1, 64'hfff0_0000_0000_0000, 0);
    send_field(MODE_DBL, 1'b0, 64'h0000_0000_0000_0000, 0);
    send_field(MODE_DBL, 1'b1, 64'h8000_0000_0000_0000, 0);
    send_field(MODE_DBL, 1'b0, 64'h3ff0_0000_0000_0000, 0);
    send_field(MODE_DBL, 1'b1, 64'hc00c_0000_0000_0001, 0);
    send_field(MODE_DBL, 1'b0, 64'h0000_0000_0000_0001, 0);
    send_field(MODE_DBL, 1'b1, 64'h800f_ffff_ffff_ffff, 0);
    send_field(MODE_DBL, 1'b0, 64'h0010_0000_0000_0000, 0);
    send_field(MODE_DBL, 1'b1, 64'h7fef_ffff_ffff_ffff, 0);
    send_field(MODE_DBL, 1'b0, 64'h0008_0000_0000_0000, 0);

    // sender pauses until everything is out
    wait_drained();

    // receiver holds off while the sender keeps offering
    long_hold = 1'b1;
    for (i = 0; i < 8; i++)
      send_field(MODE_DBL, 1'($urandom_range(0, 1)), rand_double(), 0);
    wait_drained();

    random_stall = 1'b1;
    for (i = 0; i < 132; i++) begin
      m = $urandom_range(0, 9) < 5 ? MODE_DBL : 2'($urandom_range(0, 3));
      send_field(m, 1'($urandom_range(0, 1)),
                 m == MODE_DBL ? rand_double() : rand64(),
                 (i % 40) < 10 ? 0 : $urandom_range(0, 18));
    end
    random_stall = 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);

    if (board.mismatches == 0 && board.expected_bytes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/fsp_pkg.sv
hw/rtl/fsp_front.sv
hw/rtl/fsp_queue.sv
hw/rtl/fsp_back.sv
hw/rtl/field_serializer_packer_top.sv
dv/field_serializer_packer_top_tb.sv
